// ===== rtl/jdc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jdc_pkg
// Constants, tables and types shared by the Julian day number converter.
// ----------------------------------------------------------------------------
package jdc_pkg;

  // Register stages from input to output register.
  localparam int NSTG = 7;

  localparam int DN_W   = 23;
  localparam int YEAR_W = 15;
  localparam int MON_W  = 4;
  localparam int DAY_W  = 5;

  typedef enum logic {
    ACT_DATE_TO_NUM = 1'b0,
    ACT_NUM_TO_DATE = 1'b1
  } action_t;

  localparam logic signed [15:0] YEAR_MIN  = -16'sd4712;
  localparam logic signed [15:0] YEAR_MAX  = 16'sd9999;
  localparam logic [MON_W-1:0]   MONTH_MAX = 4'd12;

  localparam logic [DN_W-1:0] MAX_DAY_NUMBER = 23'd5373484;
  localparam logic [DN_W-1:0] DAY_SWITCH     = 23'd2299161;

  // 15 Oct 1582 in day + 31 * (month + 12 * year) form
  localparam logic signed [24:0] DATE_SWITCH_CODE = 25'(15 + 31 * (10 + 12 * 1582));

  localparam logic signed [26:0] JD_OFFSET  = 27'sd1720995;
  localparam logic [24:0]        ALPHA_BIAS = 25'(4 * 1867216 + 1);
  localparam logic [23:0]        B_OFFSET   = 24'd1524;
  localparam logic [27:0]        C_BIAS     = 28'd2442;
  localparam logic signed [15:0] YEAR_BASE  = 16'sd4715;
  localparam logic [15:0]        C_DIV_BIAS = 16'd4800;
  localparam logic signed [9:0]  C_DIV_OFS  = 10'sd48;

  // Reciprocals: floor(x / d) == (x * K) >> S over the operand width used.
  localparam int S100 = 21;
  localparam logic [14:0] K100 = 15'(((64'd1 << S100) + 64'd99) / 64'd100);
  localparam int SA = 42;
  localparam logic [24:0] KA = 25'(((64'd1 << SA) + 64'd146096) / 64'd146097);
  localparam int SC = 41;
  localparam logic [28:0] KC = 29'(((64'd1 << SC) + 64'd7304) / 64'd7305);
  localparam int SE = 30;
  localparam logic [25:0] KE = 26'((((64'd1 << SE) * 64'd10000) + 64'd306000) / 64'd306001);

  // floor(30.6001 * m)
  localparam logic [8:0] MONTH_TAB [16] = '{
    9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
    9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
  };

  typedef struct packed {
    logic [NSTG-1:0] ld;
    logic [NSTG-1:0] vld;
  } pipe_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/jdc_pipe_ctl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jdc_pipe_ctl
// Valid bits and per-stage load enables; carries the action code along.
// ----------------------------------------------------------------------------
module jdc_pipe_ctl import jdc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      out_stall,
  input  action_t   act_i,
  output logic      in_stall,
  output logic      out_valid,
  output action_t   act_o,
  output pipe_ctl_t ctl
);

  logic [NSTG-1:0] vld_r, vld_nxt;
  logic [NSTG:0]   adv;
  action_t         act_r [NSTG-1];

  // a stage moves when it is empty or the one after it moves
  always_comb begin
    adv[NSTG] = !out_stall;
    for (int k = NSTG - 1; k >= 0; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  always_comb begin
    vld_nxt[0] = adv[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NSTG; k++) begin
      vld_nxt[k] = adv[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      act_r[0] <= act_i;
    end
    for (int k = 1; k < NSTG - 1; k++) begin
      if (adv[k]) begin
        act_r[k] <= act_r[k-1];
      end
    end
  end

  assign in_stall  = !adv[0];
  assign out_valid = vld_r[NSTG-1];
  assign act_o     = act_r[NSTG-2];
  assign ctl.ld    = adv[NSTG-1:0];
  assign ctl.vld   = vld_r;

  // back-pressure reaches the input only when there is no bubble anywhere
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&vld_r))
    else $error("input stalled while a stage is empty");

  a_out_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NSTG-1] && out_stall) |=> vld_r[NSTG-1])
    else $error("stalled result dropped");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (vld_r == '0))
    else $error("valid bits not cleared by reset");

endmodule
`default_nettype wire

// ===== rtl/jdc_date2num.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jdc_date2num
// Date to Julian day number: three compute stages, then delay to align.
// ----------------------------------------------------------------------------
module jdc_date2num import jdc_pkg::*; (
  input  logic                     clk,
  input  pipe_ctl_t                ctl,
  input  logic signed [YEAR_W-1:0] year_i,
  input  logic [MON_W-1:0]         month_i,
  input  logic [DAY_W-1:0]         day_i,
  output logic [DN_W-1:0]          dn_o,
  output logic                     err_o
);

  // stage 1: adjust year/month, range check, calendar select
  logic signed [15:0] yr_ext, y0, y1_nxt;
  logic [MON_W-1:0]   mi;
  logic               mon_hi;
  logic signed [24:0] yr25, mo25, dy25, code;
  logic               err1_nxt, greg1_nxt;

  always_comb begin
    yr_ext    = $signed({year_i[YEAR_W-1], year_i});
    y0        = (yr_ext < 16'sd0) ? yr_ext + 16'sd1 : yr_ext;
    mon_hi    = month_i > 4'd2;
    y1_nxt    = mon_hi ? y0 : y0 - 16'sd1;
    mi        = mon_hi ? month_i + 4'd1 : month_i + 4'd13;
    yr25      = 25'(yr_ext);
    mo25      = $signed({21'd0, month_i});
    dy25      = $signed({20'd0, day_i});
    code      = dy25 + 25'sd31 * (mo25 + 25'sd12 * yr25);
    greg1_nxt = code >= DATE_SWITCH_CODE;
    err1_nxt  = (yr_ext == 16'sd0) || (yr_ext < YEAR_MIN) || (yr_ext > YEAR_MAX) ||
                (month_i == '0) || (month_i > MONTH_MAX) || (day_i == '0);
  end

  logic signed [15:0] y1_r;
  logic [8:0]         mt1_r, mt2_r;
  logic [DAY_W-1:0]   day1_r, day2_r;
  logic               greg1_r, greg2_r;
  logic               err1_r, err2_r, err3_r, err4_r, err5_r, err6_r;

  always_ff @(posedge clk) begin
    if (ctl.ld[0]) begin
      y1_r    <= y1_nxt;
      mt1_r   <= MONTH_TAB[mi];
      day1_r  <= day_i;
      greg1_r <= greg1_nxt;
      err1_r  <= err1_nxt;
    end
  end

  // stage 2: 1461*y and floor(y/100) by reciprocal
  logic signed [26:0] p2_nxt, p2_r;
  logic [13:0]        v100;
  logic [15:0]        v100_w;
  logic [28:0]        q2_nxt, q2_r;

  always_comb begin
    p2_nxt = 27'(y1_r) * 27'sd1461;
    v100_w = 16'(y1_r) + C_DIV_BIAS;
    v100   = v100_w[13:0];
    q2_nxt = 29'(v100) * 29'(K100);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[1]) begin
      p2_r    <= p2_nxt;
      q2_r    <= q2_nxt;
      mt2_r   <= mt1_r;
      day2_r  <= day1_r;
      greg2_r <= greg1_r;
      err2_r  <= err1_r;
    end
  end

  // stage 3: sum up, Gregorian correction
  logic signed [9:0]  cent, corr;
  logic signed [26:0] p_fl, mt_s, dy_s, corr_s, n_sum;
  logic [DN_W-1:0]    n3_r, n4_r, n5_r, n6_r;

  always_comb begin
    cent   = $signed({2'b00, q2_r[28:S100]}) - C_DIV_OFS;
    corr   = 10'sd2 - cent + (cent >>> 2);
    p_fl   = p2_r >>> 2;
    mt_s   = $signed({18'd0, mt2_r});
    dy_s   = $signed({22'd0, day2_r});
    corr_s = greg2_r ? 27'(corr) : 27'sd0;
    n_sum  = p_fl + mt_s + dy_s + JD_OFFSET + corr_s;
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[2]) begin
      n3_r   <= n_sum[DN_W-1:0];
      err3_r <= err2_r;
    end
    if (ctl.ld[3]) begin
      n4_r   <= n3_r;
      err4_r <= err3_r;
    end
    if (ctl.ld[4]) begin
      n5_r   <= n4_r;
      err5_r <= err4_r;
    end
    if (ctl.ld[5]) begin
      n6_r   <= n5_r;
      err6_r <= err5_r;
    end
  end

  assign dn_o  = n6_r;
  assign err_o = err6_r;

endmodule
`default_nettype wire

// ===== rtl/jdc_num2date.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jdc_num2date
// Julian day number to date: reciprocal divides, at most one multiply per stage.
// ----------------------------------------------------------------------------
module jdc_num2date import jdc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pipe_ctl_t                ctl,
  input  logic [DN_W-1:0]          dn_i,
  output logic [DN_W-1:0]          dn_o,
  output logic                     err_o,
  output logic signed [YEAR_W-1:0] year_o,
  output logic [MON_W-1:0]         month_o,
  output logic [DAY_W-1:0]         day_o
);

  logic [DN_W-1:0] dn1_r, dn2_r, dn3_r, dn4_r, dn5_r, dn6_r;
  logic            err1_r, err2_r, err3_r, err4_r, err5_r, err6_r;
  logic            sw1_r, sw2_r;

  // stage 1: 4*(n - 1867216) - 1
  logic [24:0] axw;
  logic [23:0] ax1_r;

  assign axw = {dn_i, 2'b00} - ALPHA_BIAS;

  always_ff @(posedge clk) begin
    if (ctl.ld[0]) begin
      dn1_r  <= dn_i;
      err1_r <= dn_i > MAX_DAY_NUMBER;
      sw1_r  <= dn_i >= DAY_SWITCH;
      ax1_r  <= axw[23:0];
    end
  end

  // stage 2: alpha product
  logic [48:0] pa2_r;

  always_ff @(posedge clk) begin
    if (ctl.ld[1]) begin
      pa2_r  <= 49'(ax1_r) * 49'(KA);
      dn2_r  <= dn1_r;
      err2_r <= err1_r;
      sw2_r  <= sw1_r;
    end
  end

  // stage 3: a, b, 20*b - 2442
  logic [6:0]  alpha;
  logic [23:0] a_val, b_val;
  logic [27:0] t_val;

  always_comb begin
    alpha = pa2_r[48:SA];
    a_val = sw2_r ? 24'(dn2_r) + 24'd1 + 24'(alpha) - 24'(alpha >> 2) : 24'(dn2_r);
    b_val = a_val + B_OFFSET;
    t_val = 28'(b_val) * 28'd20 - C_BIAS;
  end

  logic [23:0] b3_r, b4_r;
  logic [27:0] t3_r;

  always_ff @(posedge clk) begin
    if (ctl.ld[2]) begin
      b3_r   <= b_val;
      t3_r   <= t_val;
      dn3_r  <= dn2_r;
      err3_r <= err2_r;
    end
  end

  // stage 4: c product
  logic [56:0] pc4_r;

  always_ff @(posedge clk) begin
    if (ctl.ld[3]) begin
      pc4_r  <= 57'(t3_r) * 57'(KC);
      b4_r   <= b3_r;
      dn4_r  <= dn3_r;
      err4_r <= err3_r;
    end
  end

  // stage 5: c, days before the year start, day within the year
  logic [14:0] c_val;
  logic [24:0] d_val, bd_w;

  always_comb begin
    c_val = pc4_r[SC+14:SC];
    d_val = 25'(c_val) * 25'd365 + 25'(c_val >> 2);
    bd_w  = 25'(b4_r) - d_val;
  end

  logic [14:0] c5_r, c6_r;
  logic [9:0]  bd5_r, bd6_r;

  always_ff @(posedge clk) begin
    if (ctl.ld[4]) begin
      c5_r   <= c_val;
      bd5_r  <= bd_w[9:0];
      dn5_r  <= dn4_r;
      err5_r <= err4_r;
    end
  end

  // stage 6: month index product
  logic [35:0] pe6_r;

  always_ff @(posedge clk) begin
    if (ctl.ld[5]) begin
      pe6_r  <= 36'(bd5_r) * 36'(KE);
      bd6_r  <= bd5_r;
      c6_r   <= c5_r;
      dn6_r  <= dn5_r;
      err6_r <= err5_r;
    end
  end

  // into the output register: day, month, year
  logic [MON_W-1:0]   e_idx, m_raw, m_fix;
  logic [9:0]         dday;
  logic signed [15:0] y0, y1, y2;

  always_comb begin
    e_idx = pe6_r[SE+3:SE];
    dday  = bd6_r - 10'(MONTH_TAB[e_idx]);
    m_raw = e_idx - 4'd1;
    m_fix = (m_raw > MONTH_MAX) ? m_raw - MONTH_MAX : m_raw;
    y0    = $signed({1'b0, c6_r}) - YEAR_BASE;
    y1    = (m_fix > 4'd2) ? y0 - 16'sd1 : y0;
    // no year zero: 0 and below shift down by one
    y2    = (y1 <= 16'sd0) ? y1 - 16'sd1 : y1;
  end

  assign dn_o    = dn6_r;
  assign err_o   = err6_r;
  assign year_o  = y2[YEAR_W-1:0];
  assign month_o = m_fix;
  assign day_o   = dday[DAY_W-1:0];

  a_date_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.vld[NSTG-2] && !err6_r) |->
      (month_o != '0 && month_o <= MONTH_MAX && day_o != '0))
    else $error("day number decoded to an impossible month or day");

endmodule
`default_nettype wire

// ===== rtl/julian_day_converter_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// julian_day_converter_top
// Julian day number <-> calendar date converter, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall  in_action, in_year, in_month, in_day,
//                                in_day_number
//  out      out_valid/out_stall  out_day_number, out_year, out_month,
//                                out_day, out_range_error
//
//  One transaction is accepted every cycle while in_stall is low.
//  The depth is set by the chain of three reciprocal multiplies in the
//  day-number-to-date path, one multiply per stage.
//  Synchronous reset clears all valid bits; payload registers are not reset.
//  out_stall holds the output register; empty stages still fill, and
//  in_stall rises only when every stage is occupied.
// ----------------------------------------------------------------------------
module julian_day_converter_top import jdc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_action,
  input  logic signed [YEAR_W-1:0] in_year,
  input  logic [MON_W-1:0]         in_month,
  input  logic [DAY_W-1:0]         in_day,
  input  logic [DN_W-1:0]          in_day_number,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [DN_W-1:0]          out_day_number,
  output logic signed [YEAR_W-1:0] out_year,
  output logic [MON_W-1:0]         out_month,
  output logic [DAY_W-1:0]         out_day,
  output logic                     out_range_error
);

  pipe_ctl_t ctl;
  action_t   act_last;

  jdc_pipe_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .act_i     (action_t'(in_action)),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .act_o     (act_last),
    .ctl       (ctl)
  );

  logic [DN_W-1:0] d2n_dn;
  logic            d2n_err;

  jdc_date2num u_d2n (
    .clk     (clk),
    .ctl     (ctl),
    .year_i  (in_year),
    .month_i (in_month),
    .day_i   (in_day),
    .dn_o    (d2n_dn),
    .err_o   (d2n_err)
  );

  logic [DN_W-1:0]          n2d_dn;
  logic                     n2d_err;
  logic signed [YEAR_W-1:0] n2d_year;
  logic [MON_W-1:0]         n2d_month;
  logic [DAY_W-1:0]         n2d_day;

  jdc_num2date u_n2d (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .dn_i    (in_day_number),
    .dn_o    (n2d_dn),
    .err_o   (n2d_err),
    .year_o  (n2d_year),
    .month_o (n2d_month),
    .day_o   (n2d_day)
  );

  logic [DN_W-1:0]          dn_nxt, dn_r;
  logic signed [YEAR_W-1:0] year_nxt, year_r;
  logic [MON_W-1:0]         month_nxt, month_r;
  logic [DAY_W-1:0]         day_nxt, day_r;
  logic                     err_nxt, err_r;

  always_comb begin
    unique case (act_last)
      ACT_DATE_TO_NUM: begin
        dn_nxt    = d2n_err ? '0 : d2n_dn;
        year_nxt  = '0;
        month_nxt = '0;
        day_nxt   = '0;
        err_nxt   = d2n_err;
      end
      ACT_NUM_TO_DATE: begin
        dn_nxt    = n2d_dn;
        year_nxt  = n2d_err ? '0 : n2d_year;
        month_nxt = n2d_err ? '0 : n2d_month;
        day_nxt   = n2d_err ? '0 : n2d_day;
        err_nxt   = n2d_err;
      end
      default: begin
        dn_nxt    = '0;
        year_nxt  = '0;
        month_nxt = '0;
        day_nxt   = '0;
        err_nxt   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[NSTG-1]) begin
      dn_r    <= dn_nxt;
      year_r  <= year_nxt;
      month_r <= month_nxt;
      day_r   <= day_nxt;
      err_r   <= err_nxt;
    end
  end

  assign out_day_number  = dn_r;
  assign out_year        = year_r;
  assign out_month       = month_r;
  assign out_day         = day_r;
  assign out_range_error = err_r;

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for julian_day_converter_top. Dates and day numbers
// are pushed through the valid/stall input channel with random idle bursts.
// Each accepted transaction is converted by an integer model of the calendar
// rules kept in a scoreboard. Results are popped in order and compared
// field by field while the output side stalls in random bursts.
// ----------------------------------------------------------------------------
module tb;
  import jdc_pkg::*;

  localparam int N_RANDOM       = 2000;
  localparam int CALM_TAIL      = 300;
  localparam int WATCHDOG_LIMIT = 500;

  // Integer calendar model plus the queue of results still owed by the DUT.
  class conv_scoreboard;
    typedef struct packed {
      logic [DN_W-1:0]          dn;
      logic signed [YEAR_W-1:0] year;
      logic [MON_W-1:0]         month;
      logic [DAY_W-1:0]         day;
      logic                     err;
    } conv_result_t;

    localparam longint GREG_DATE_CODE = 15 + 31 * (10 + 12 * 1582);
    localparam longint GREG_FIRST_DAY = 2299161;

    conv_result_t owed[$];
    int mismatches;
    int n_results;
    int n_dates;
    int n_numbers;
    int n_flagged;

    function longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if (n % d != 0 && n < 0) q--;
      return q;
    endfunction

    function longint date_to_jdn(longint yr, longint mo, longint dy);
      longint y, m, n, c;
      y = (yr < 0) ? yr + 1 : yr;
      if (mo > 2) begin
        m = mo + 1;
      end else begin
        y--;
        m = mo + 13;
      end
      n = floor_div(1461 * y, 4) + floor_div(306001 * m, 10000) + dy + 1720995;
      // Gregorian correction applies from 15 Oct 1582 on
      if (dy + 31 * (mo + 12 * yr) >= GREG_DATE_CODE) begin
        c = floor_div(y, 100);
        n += 2 - c + floor_div(c, 4);
      end
      return n;
    endfunction

    function void jdn_to_date(longint jd, output longint yr, output longint mo,
                              output longint dy);
      longint alpha, a, b, c, d, e;
      if (jd >= GREG_FIRST_DAY) begin
        alpha = floor_div(4 * (jd - 1867216) - 1, 146097);
        a = jd + 1 + alpha - floor_div(alpha, 4);
      end else begin
        a = jd;
      end
      b = a + 1524;
      c = floor_div(20 * b - 2442, 7305);
      d = 365 * c + floor_div(c, 4);
      e = floor_div(10000 * (b - d), 306001);
      dy = b - d - floor_div(306001 * e, 10000);
      mo = e - 1;
      if (mo > 12) mo -= 12;
      yr = c - 4715;
      if (mo > 2) yr--;
      // no year zero
      if (yr <= 0) yr--;
    endfunction

    function void note_input(action_t act, logic signed [YEAR_W-1:0] yr,
                             logic [MON_W-1:0] mo, logic [DAY_W-1:0] dy,
                             logic [DN_W-1:0] dn);
      conv_result_t r;
      longint y, m, d;
      r = '0;
      if (act == ACT_DATE_TO_NUM) begin
        n_dates++;
        y = yr;
        if (y == 0 || y < YEAR_MIN || y > YEAR_MAX || mo == 0 || mo > MONTH_MAX ||
            dy == 0)
          r.err = 1'b1;
        else
          r.dn = DN_W'(date_to_jdn(y, longint'(mo), longint'(dy)));
      end else begin
        n_numbers++;
        r.dn = dn;
        if (dn > MAX_DAY_NUMBER) begin
          r.err = 1'b1;
        end else begin
          jdn_to_date(longint'(dn), y, m, d);
          r.year  = YEAR_W'(y);
          r.month = MON_W'(m);
          r.day   = DAY_W'(d);
        end
      end
      if (r.err) n_flagged++;
      owed.push_back(r);
    endfunction

    function void check_result(logic [DN_W-1:0] dn, logic signed [YEAR_W-1:0] yr,
                               logic [MON_W-1:0] mo, logic [DAY_W-1:0] dy,
                               logic err);
      conv_result_t w;
      n_results++;
      if (owed.size() == 0) begin
        $error("result transaction with none outstanding: day_number %0d", dn);
        mismatches++;
        return;
      end
      w = owed.pop_front();
      if (dn !== w.dn) begin
        $error("out_day_number: expected %0d, got %0d", w.dn, dn);
        mismatches++;
      end
      if (yr !== w.year) begin
        $error("out_year: expected %0d, got %0d", w.year, yr);
        mismatches++;
      end
      if (mo !== w.month) begin
        $error("out_month: expected %0d, got %0d", w.month, mo);
        mismatches++;
      end
      if (dy !== w.day) begin
        $error("out_day: expected %0d, got %0d", w.day, dy);
        mismatches++;
      end
      if (err !== w.err) begin
        $error("out_range_error: expected %0b, got %0b", w.err, err);
        mismatches++;
      end
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_action;
  logic signed [YEAR_W-1:0] in_year;
  logic [MON_W-1:0]         in_month;
  logic [DAY_W-1:0]         in_day;
  logic [DN_W-1:0]          in_day_number;
  logic                     out_valid;
  logic                     out_stall;
  logic [DN_W-1:0]          out_day_number;
  logic signed [YEAR_W-1:0] out_year;
  logic [MON_W-1:0]         out_month;
  logic [DAY_W-1:0]         out_day;
  logic                     out_range_error;

  conv_scoreboard sb = new();
  int  gap_pct   = 10;
  int  stall_pct = 10;
  bit  calm      = 1'b0;
  int  quiet_cycles = 0;

  julian_day_converter_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_year         (in_year),
    .in_month        (in_month),
    .in_day          (in_day),
    .in_day_number   (in_day_number),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_day_number  (out_day_number),
    .out_year        (out_year),
    .out_month       (out_month),
    .out_day         (out_day),
    .out_range_error (out_range_error)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Called right after a rising edge; returns at the edge that accepts.
  task automatic put_item(action_t act, int yr, int mo, int dy, int dn);
    in_valid      <= 1'b1;
    in_action     <= act;
    in_year       <= YEAR_W'(yr);
    in_month      <= MON_W'(mo);
    in_day        <= DAY_W'(dy);
    in_day_number <= DN_W'(dn);
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic feed(action_t act, int yr, int mo, int dy, int dn);
    if (!calm && gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(14, 1)) @(posedge clk);
    end
    put_item(act, yr, mo, dy, dn);
  endtask

  task automatic feed_random();
    int kind, yr, dn;
    kind = $urandom_range(99);
    if (kind < 40) begin
      case ($urandom_range(7))
        0: yr = 1580 + $urandom_range(4);
        1: yr = $urandom_range(6) - 3;
        default: yr = $urandom_range(14711) - 4712;
      endcase
      if (yr == 0) yr = 1;
      feed(ACT_DATE_TO_NUM, yr, $urandom_range(12, 1), $urandom_range(31, 1), $urandom);
    end else if (kind < 80) begin
      case ($urandom_range(7))
        0, 1: dn = 2299161 + $urandom_range(800) - 400;
        2: dn = $urandom_range(800);
        default: dn = $urandom_range(5373484);
      endcase
      feed(ACT_NUM_TO_DATE, $urandom, $urandom, $urandom, dn);
    end else begin
      // raw bit patterns on every field, mostly out of range
      feed(action_t'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  // Output side back-pressure in bursts.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(14, 1)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && in_stall === 1'b0) begin
        sb.note_input(action_t'(in_action), in_year, in_month, in_day, in_day_number);
        moved = 1'b1;
      end
      if (out_valid === 1'b1 && !out_stall) begin
        sb.check_result(out_day_number, out_year, out_month, out_day, out_range_error);
        moved = 1'b1;
      end
    end
    if (moved) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               quiet_cycles, sb.pending());
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_action     = ACT_DATE_TO_NUM;
    in_year       = '0;
    in_month      = '0;
    in_day        = '0;
    in_day_number = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: range limits, calendar switch, year zero, invalid fields.
    feed(ACT_DATE_TO_NUM, -4712, 1, 1, 0);
    feed(ACT_DATE_TO_NUM, 9999, 12, 31, 8388607);
    feed(ACT_DATE_TO_NUM, 1582, 10, 4, 0);
    feed(ACT_DATE_TO_NUM, 1582, 10, 15, 0);
    feed(ACT_DATE_TO_NUM, 1582, 10, 10, 0);   // inside the dropped days
    feed(ACT_DATE_TO_NUM, -1, 12, 31, 0);
    feed(ACT_DATE_TO_NUM, 1, 1, 1, 0);
    feed(ACT_DATE_TO_NUM, 2000, 2, 30, 0);    // day past month end
    feed(ACT_DATE_TO_NUM, 0, 6, 15, 0);
    feed(ACT_DATE_TO_NUM, -4713, 12, 31, 0);
    feed(ACT_DATE_TO_NUM, 10000, 1, 1, 0);
    feed(ACT_DATE_TO_NUM, 16383, 15, 31, 0);
    feed(ACT_DATE_TO_NUM, -16384, 1, 1, 0);
    feed(ACT_DATE_TO_NUM, 2020, 0, 5, 0);
    feed(ACT_DATE_TO_NUM, 2020, 13, 5, 0);
    feed(ACT_DATE_TO_NUM, 2020, 6, 0, 0);
    feed(ACT_DATE_TO_NUM, 2020, 15, 31, 0);
    feed(ACT_NUM_TO_DATE, 0, 0, 0, 0);        // lands in year -4713
    feed(ACT_NUM_TO_DATE, -1, 15, 31, 37);
    feed(ACT_NUM_TO_DATE, 0, 0, 0, 2299160);
    feed(ACT_NUM_TO_DATE, 0, 0, 0, 2299161);
    feed(ACT_NUM_TO_DATE, 0, 0, 0, 1721424);
    feed(ACT_NUM_TO_DATE, 0, 0, 0, 5373484);
    feed(ACT_NUM_TO_DATE, 0, 0, 0, 5373485);
    feed(ACT_NUM_TO_DATE, 0, 0, 0, 8388607);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 200 == 0) begin
        case ($urandom_range(2))
          0: begin gap_pct = 0;  stall_pct = 0;  end
          1: begin gap_pct = 8;  stall_pct = 8;  end
          default: begin gap_pct = 30; stall_pct = 30; end
        endcase
      end
      if (i == N_RANDOM - CALM_TAIL) calm = 1'b1;
      feed_random();
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (NSTG + 5) @(posedge clk);

    $display("Ran %0d date conversions and %0d day number conversions, %0d out of range.",
             sb.n_dates, sb.n_numbers, sb.n_flagged);
    $display("Checked %0d results with %0d field mismatches.", sb.n_results, sb.mismatches);
    if (sb.mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
